@@ rtl/core/bbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants of the 3x3 RGBA box blur
// Payload types, column-sum record, widths and the reciprocal table used to
// divide a window sum by its neighbor count.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int BBR_MAX_WIDTH = 1024;
  localparam int FW_W          = 11;
  localparam int CH_W          = 8;
  localparam int NCH           = 4;
  localparam int PIX_W         = NCH * CH_W;
  localparam int CSUM_W        = 10;
  localparam int CCNT_W        = 2;
  localparam int WSUM_W        = 12;
  localparam int WCNT_W        = 4;
  localparam int WIN_CNT_MAX   = 9;
  localparam int RECIP_W       = 17;
  localparam int RECIP_SHIFT   = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int APB_DW        = 32;
  localparam int PADDR_W       = 3;

  localparam logic [FW_W-1:0] FW_RESET = 11'd512;
  localparam logic [0:0] CFG_IDX_FRAME_WIDTH = 1'b0;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } bbr_op_t;

  typedef struct packed {
    bbr_op_t          opcode;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
  } bbr_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_alpha;
    logic             last_in_frame;
  } bbr_out_t;

  // One vertical column sum with its row count and the release decision.
  typedef struct packed {
    logic [NCH-1:0][CSUM_W-1:0] sum;
    logic [CCNT_W-1:0]          cnt;
    logic                       rel;
    logic                       has_left;
    logic                       has_right;
    logic                       last;
  } bbr_col_t;

  // Ceiling of 2^16 / cnt; exact floor division for sums below 4096.
  function automatic logic [RECIP_W-1:0] bbr_recip(input logic [WCNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/bbr_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_stream_if: valid/ready stream channel
// Carries valid, ready and one payload of a parameter type.
// ----------------------------------------------------------------------------
interface bbr_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/box_blur_3x3_rgba.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba: 3x3 mean filter over a square RGBA frame
// Raster-order pixels in, blurred pixels out one row and one column later;
// drain items release the held last row. APB register sets the frame width.
//
//   Channel   Direction  Handshake                    Contents
//   in_ch     in         valid/ready                  opcode, red, green, blue, alpha
//   out_ch    out        valid/ready                  out_red..out_alpha, last_in_frame
//   APB       in/out     psel, penable, pwrite        frame_width at address 0
//
// One item per clock is sustained while the output is not stalled; the single
// read port of each line store is read once per item.
// Reset clears the control state only; the line stores are not cleared, and
// an entry is always written before it is used within a frame.
// An output stall fills the output stage, the window stage, the two-entry
// queue and the front stage before input ready drops.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgba #(
  parameter int MAX_WIDTH = bbr_pkg::BBR_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bbr_stream_if.sink                   in_ch,
  bbr_stream_if.source                 out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bbr_pkg::PADDR_W-1:0]  paddr,
  input  logic [bbr_pkg::APB_DW-1:0]   pwdata,
  output logic [bbr_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import bbr_pkg::*;

  logic [FW_W-1:0] fw_r, fw_nxt;
  logic            cfg_wr;
  logic            reg_hit;
  logic            q_push, q_full, q_pop, q_empty;
  bbr_col_t        q_wr_data, q_rd_data;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == CFG_IDX_FRAME_WIDTH);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign fw_nxt  = cfg_wr ? pwdata[FW_W-1:0] : fw_r;
  assign prdata  = reg_hit ? APB_DW'(fw_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
    end else begin
      fw_r <= fw_nxt;
    end
  end

  bbr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_width (fw_r),
    .restart     (cfg_wr),
    .in_ch       (in_ch),
    .q_push      (q_push),
    .q_data      (q_wr_data),
    .q_full      (q_full)
  );

  bbr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .empty     (q_empty)
  );

  bbr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/core/bbr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_ram: simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/bbr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_front: input side of the box blur
// Accepts items, drops those that do not apply, tracks the input position,
// reads and updates the two line stores and forms one column sum per item.
// ----------------------------------------------------------------------------
module bbr_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [bbr_pkg::FW_W-1:0] frame_width,
  input  logic                    restart,
  bbr_stream_if.sink              in_ch,
  output logic                    q_push,
  output bbr_pkg::bbr_col_t       q_data,
  input  logic                    q_full
);
  import bbr_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 2);
  localparam int CMPW = (WW > FW_W) ? WW : FW_W;

  logic [WW-1:0]   w;
  logic [CMPW-1:0] fw_x;
  logic [AW-1:0]   in_col_r, in_col_nxt;
  logic [WW-1:0]   in_row_r, in_row_nxt;
  logic [WW-1:0]   col_ext;
  logic            is_drain, ignore, accept, take, last_now;
  logic            f1_v_r, f1_v_nxt, f1_pop, wr_en;

  logic [NCH-1:0][CH_W-1:0] pix_ch;
  logic [NCH-1:0][CH_W-1:0] f1_pix_r;
  logic [AW-1:0]            f1_addr_r;
  logic                     f1_inc_pix_r, f1_use_new_r, f1_use_old_r, f1_wr_r;
  logic                     f1_rel_r, f1_hl_r, f1_hr_r, f1_last_r;

  logic [NCH-1:0][CH_W-1:0] new_q, old_q, new_eff, old_eff;
  logic [NCH-1:0][CH_W-1:0] fwd_new_r, fwd_old_r;
  logic                     fwd_hit_r;

  always_comb begin
    fw_x = CMPW'(frame_width);
    if (fw_x == '0) begin
      w = WW'(1);
    end else if (fw_x > CMPW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(fw_x);
    end
  end

  assign col_ext  = WW'(in_col_r);
  assign is_drain = (in_ch.payload.opcode == OP_DRAIN);
  assign ignore   = is_drain ? (in_row_r < w) : (in_row_r >= w);
  assign f1_pop   = f1_v_r && !q_full;
  assign in_ch.ready = !f1_v_r || !q_full;
  assign accept   = in_ch.valid && in_ch.ready;
  assign take     = accept && !ignore;
  assign last_now = (in_row_r == WW'(w + WW'(1))) && (in_col_r == '0);
  assign pix_ch   = {in_ch.payload.alpha, in_ch.payload.blue,
                     in_ch.payload.green, in_ch.payload.red};

  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    f1_v_nxt   = f1_v_r;
    if (f1_pop) begin
      f1_v_nxt = 1'b0;
    end
    if (take) begin
      f1_v_nxt = 1'b1;
      if (last_now) begin
        in_row_nxt = '0;
        in_col_nxt = '0;
      end else if (col_ext == WW'(w - WW'(1))) begin
        in_col_nxt = '0;
        in_row_nxt = WW'(in_row_r + WW'(1));
      end else begin
        in_col_nxt = AW'(in_col_r + AW'(1));
      end
    end
    if (restart) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
      f1_v_r   <= 1'b0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      f1_v_r   <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f1_pix_r     <= pix_ch;
      f1_addr_r    <= in_col_r;
      f1_wr_r      <= !is_drain;
      f1_inc_pix_r <= !is_drain;
      f1_use_new_r <= is_drain ? (in_row_r == w) : (in_row_r >= WW'(1));
      f1_use_old_r <= is_drain ? ((in_row_r == w) && (w >= WW'(2)))
                               : (in_row_r >= WW'(2));
      f1_rel_r     <= (in_row_r >= WW'(2)) || ((in_row_r == WW'(1)) && (in_col_r != '0));
      f1_hl_r      <= (in_col_r == '0) ? (w >= WW'(2)) : (col_ext >= WW'(2));
      f1_hr_r      <= (in_col_r != '0);
      f1_last_r    <= last_now;
      fwd_hit_r    <= wr_en && (f1_addr_r == in_col_r);
      fwd_new_r    <= f1_pix_r;
      fwd_old_r    <= new_eff;
    end
  end

  assign wr_en = f1_pop && f1_wr_r;

  bbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (f1_addr_r),
    .wr_data (f1_pix_r),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (new_q)
  );

  bbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (f1_addr_r),
    .wr_data (new_eff),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (old_q)
  );

  // The previous item may have written this address in the same cycle.
  assign new_eff = fwd_hit_r ? fwd_new_r : new_q;
  assign old_eff = fwd_hit_r ? fwd_old_r : old_q;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      q_data.sum[k] = (f1_inc_pix_r ? CSUM_W'(f1_pix_r[k]) : '0)
                    + (f1_use_new_r ? CSUM_W'(new_eff[k]) : '0)
                    + (f1_use_old_r ? CSUM_W'(old_eff[k]) : '0);
    end
    q_data.cnt = CCNT_W'(f1_inc_pix_r) + CCNT_W'(f1_use_new_r) + CCNT_W'(f1_use_old_r);
    q_data.rel       = f1_rel_r;
    q_data.has_left  = f1_hl_r;
    q_data.has_right = f1_hr_r;
    q_data.last      = f1_last_r;
  end

  assign q_push = f1_pop;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_ext < w)
    else $error("input column outside the frame");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= WW'(w + WW'(1)))
    else $error("input row past the drain rows");

endmodule

@@ rtl/core/bbr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_queue: short queue of column sums
// Decouples the front from the back so each side can stall on its own.
// ----------------------------------------------------------------------------
module bbr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bbr_pkg::bbr_col_t push_data,
  output logic              full,
  input  logic              pop,
  output bbr_pkg::bbr_col_t pop_data,
  output logic              empty
);
  import bbr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bbr_col_t       store [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = store[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + PW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? PW'(rd_ptr_r + PW'(1)) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CW'(count_r + CW'(1));
    end else if (pop && !push) begin
      count_nxt = CW'(count_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

endmodule

@@ rtl/core/bbr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbr_back: window and divide side of the box blur
// Holds the last two column sums, adds the 3x3 window, divides each channel
// by the neighbor count through a reciprocal multiply and drives the output.
// ----------------------------------------------------------------------------
module bbr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bbr_pkg::bbr_col_t q_data,
  output logic              q_pop,
  bbr_stream_if.source      out_ch
);
  import bbr_pkg::*;

  localparam int PROD_W = WSUM_W + RECIP_W;

  logic [NCH-1:0][CSUM_W-1:0] win0_sum_r, win1_sum_r;
  logic [CCNT_W-1:0]          win0_cnt_r, win1_cnt_r;

  logic                       b1_v_r, b1_v_nxt, b1_free, b2_load;
  logic [NCH-1:0][WSUM_W-1:0] b1_sum_r, b1_sum_nxt;
  logic [WCNT_W-1:0]          b1_cnt_r, b1_cnt_nxt;
  logic                       b1_last_r;

  logic                       out_v_r, out_v_nxt;
  bbr_out_t                   out_d_r;
  logic [RECIP_W-1:0]         recip;
  logic [NCH-1:0][PROD_W-1:0] prod;
  logic [NCH-1:0][CH_W-1:0]   quot;

  assign b2_load = b1_v_r && (!out_v_r || out_ch.ready);
  assign b1_free = !b1_v_r || b2_load;
  assign q_pop   = !q_empty && b1_free;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      b1_sum_nxt[k] = WSUM_W'(win1_sum_r[k])
                    + (q_data.has_left  ? WSUM_W'(win0_sum_r[k]) : '0)
                    + (q_data.has_right ? WSUM_W'(q_data.sum[k]) : '0);
    end
    b1_cnt_nxt = WCNT_W'(win1_cnt_r)
               + (q_data.has_left  ? WCNT_W'(win0_cnt_r) : '0)
               + (q_data.has_right ? WCNT_W'(q_data.cnt) : '0);
    b1_v_nxt = b1_v_r;
    if (q_pop) begin
      b1_v_nxt = q_data.rel;
    end else if (b2_load) begin
      b1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (b2_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b1_v_r  <= b1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // The window does not advance on the final output of a frame.
  always_ff @(posedge clk) begin
    if (q_pop && !(q_data.rel && q_data.last)) begin
      win0_sum_r <= win1_sum_r;
      win0_cnt_r <= win1_cnt_r;
      win1_sum_r <= q_data.sum;
      win1_cnt_r <= q_data.cnt;
    end
    if (q_pop && q_data.rel) begin
      b1_sum_r  <= b1_sum_nxt;
      b1_cnt_r  <= b1_cnt_nxt;
      b1_last_r <= q_data.last;
    end
  end

  assign recip = bbr_recip(b1_cnt_r);

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      prod[k] = PROD_W'(b1_sum_r[k]) * PROD_W'(recip);
      quot[k] = prod[k][RECIP_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (b2_load) begin
      out_d_r.out_red       <= quot[0];
      out_d_r.out_green     <= quot[1];
      out_d_r.out_blue      <= quot[2];
      out_d_r.out_alpha     <= quot[3];
      out_d_r.last_in_frame <= b1_last_r;
    end
  end

  assign out_ch.valid   = out_v_r;
  assign out_ch.payload = out_d_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    b1_v_r |-> (b1_cnt_r != '0) && (b1_cnt_r <= WCNT_W'(WIN_CNT_MAX)))
    else $error("window neighbor count out of range");

endmodule
